FILE: sv/m68ea_pkg.sv
// m68ea_pkg: codes, field constants and payload types for the 68020 effective address decoder
// no dependencies; imported by the top level, m68ea_index and m68ea_decode
`timescale 1ns / 1ps
`default_nettype none

package m68ea_pkg;

    // operand kinds
    localparam logic [3:0] KIND_REG      = 4'd0;
    localparam logic [3:0] KIND_DEFER    = 4'd1;
    localparam logic [3:0] KIND_POSTINC  = 4'd2;
    localparam logic [3:0] KIND_PREDEC   = 4'd3;
    localparam logic [3:0] KIND_DISPL    = 4'd4;
    localparam logic [3:0] KIND_INDEX    = 4'd5;
    localparam logic [3:0] KIND_ABS_W    = 4'd6;
    localparam logic [3:0] KIND_ABS_L    = 4'd7;
    localparam logic [3:0] KIND_PC_DISPL = 4'd8;
    localparam logic [3:0] KIND_PC_INDEX = 4'd9;
    localparam logic [3:0] KIND_IMM      = 4'd10;
    localparam logic [3:0] KIND_INVALID  = 4'd11;

    // mode field
    localparam logic [2:0] MODE_DREG    = 3'd0;
    localparam logic [2:0] MODE_AREG    = 3'd1;
    localparam logic [2:0] MODE_DEFER   = 3'd2;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;
    localparam logic [2:0] MODE_DISPL   = 3'd5;
    localparam logic [2:0] MODE_INDEX   = 3'd6;
    localparam logic [2:0] MODE_EXT     = 3'd7;

    // register field under mode 7
    localparam logic [2:0] EXT_ABS_W    = 3'd0;
    localparam logic [2:0] EXT_ABS_L    = 3'd1;
    localparam logic [2:0] EXT_PC_DISPL = 3'd2;
    localparam logic [2:0] EXT_PC_INDEX = 3'd3;
    localparam logic [2:0] EXT_IMM      = 3'd4;

    // operand sizes that change the immediate fetch
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_LONG = 3'd4;
    localparam logic [31:0] IMM_BYTE_MASK = 32'h0000_00ff;

    // displacement size codes of the full extension word
    localparam logic [1:0] DSZ_WORD = 2'd2;
    localparam logic [1:0] DSZ_LONG = 2'd3;

    // flag bit positions
    localparam int FLAG_BSUP   = 0;
    localparam int FLAG_WDISP  = 1;
    localparam int FLAG_LDISP  = 2;
    localparam int FLAG_PRE    = 3;
    localparam int FLAG_POST   = 4;
    localparam int FLAG_IND    = 5;
    localparam int FLAG_WDISP2 = 6;
    localparam int FLAG_LDISP2 = 7;

    localparam int NUM_WORDS = 5;

    typedef logic [NUM_WORDS-1:0][15:0] t_words;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  reg_req;
        logic [2:0]  size;
        logic [31:0] ext_addr;
        t_words      words;
    } t_ea_req;

    typedef struct packed {
        logic [3:0]  operand_type;
        logic [3:0]  base_register;
        logic [31:0] value;
        logic        index_is_word;
        logic [3:0]  scale;
        logic [7:0]  flags;
        logic [31:0] base_disp;
        logic [31:0] outer_disp;
        logic [2:0]  words_used;
    } t_ea_res;

    typedef struct packed {
        logic [3:0]  index_reg;
        logic        index_is_word;
        logic [3:0]  scale;
        logic [7:0]  flags;
        logic [31:0] base_disp;
        logic [31:0] outer_disp;
        logic [2:0]  words_used;
    } t_idx_res;

    function automatic logic [31:0] sext16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

endpackage

`default_nettype wire

FILE: sv/m68ea_in_if.sv
// m68ea_in_if: request channel carrying one effective address and its extension words
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface m68ea_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [2:0]  size;
    logic [31:0] ext_addr;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [15:0] word4;

    modport source (
        output valid, mode, reg_req, size, ext_addr, word0, word1, word2, word3, word4,
        input  ready
    );
    modport sink (
        input  valid, mode, reg_req, size, ext_addr, word0, word1, word2, word3, word4,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/m68ea_out_if.sv
// m68ea_out_if: result channel carrying one decoded effective address
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface m68ea_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operand_type;
    logic [3:0]         base_register;
    logic signed [31:0] value;
    logic               index_is_word;
    logic [3:0]         scale;
    logic [7:0]         flags;
    logic signed [31:0] base_disp;
    logic signed [31:0] outer_disp;
    logic [2:0]         words_used;

    modport source (
        output valid, operand_type, base_register, value, index_is_word, scale, flags,
               base_disp, outer_disp, words_used,
        input  ready
    );
    modport sink (
        input  valid, operand_type, base_register, value, index_is_word, scale, flags,
               base_disp, outer_disp, words_used,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/m68020_effective_address_decoder.sv
// m68020_effective_address_decoder: 68000/68020 effective address decoder top level
// depends on m68ea_pkg, m68ea_in_if, m68ea_out_if and m68ea_decode
//
// Decodes one effective address per transfer: the mode and register fields plus up to
// five extension words in stream order give the operand kind, base register, value or
// index register, index width and scale, a flag mask, base and outer displacements and
// the number of extension words consumed. Brief and full index formats, memory
// indirection before and after indexing, base/index suppression, PC-relative binding
// and byte immediate masking are handled. The block is a two-register pipeline: a
// request register feeding one pass of decode logic into a result register. A new
// request can be taken every cycle while the result side is not stalled; each request
// is decoded from the request register and its result is held in the result register
// until it transfers. Back-pressure on the result channel ripples back through the
// ready chain; nothing is lost or repeated. No configuration and no state between
// requests.
`timescale 1ns / 1ps
`default_nettype none

module m68020_effective_address_decoder
    import m68ea_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    m68ea_in_if.sink   i_ea,
    m68ea_out_if.source o_res
);

    // request stage
    logic    r_req_valid;
    logic    n_req_valid;
    t_ea_req r_req;
    t_ea_req n_req;

    // result stage
    logic    r_res_valid;
    logic    n_res_valid;
    t_ea_res r_res;
    t_ea_res n_res;

    t_ea_res dec_res;
    logic    req_ready;
    logic    res_ready;
    logic    in_xfer;
    logic    adv;

    // result register frees when empty or its transfer completes this cycle
    assign res_ready = !r_res_valid || o_res.ready;
    // request register frees when empty or its item moves on to the result register
    assign req_ready = !r_req_valid || res_ready;
    assign in_xfer   = i_ea.valid && req_ready;
    assign adv       = r_req_valid && res_ready;

    assign i_ea.ready = req_ready;

    m68ea_decode u_decode (
        .i_req (r_req),
        .o_res (dec_res)
    );

    always_comb begin
        n_req_valid = r_req_valid;
        n_req       = r_req;
        if (req_ready) begin
            n_req_valid = i_ea.valid;
        end
        if (in_xfer) begin
            n_req.mode     = i_ea.mode;
            n_req.reg_req  = i_ea.reg_req;
            n_req.size     = i_ea.size;
            n_req.ext_addr = i_ea.ext_addr;
            n_req.words[0] = i_ea.word0;
            n_req.words[1] = i_ea.word1;
            n_req.words[2] = i_ea.word2;
            n_req.words[3] = i_ea.word3;
            n_req.words[4] = i_ea.word4;
        end
    end

    always_comb begin
        n_res_valid = r_res_valid;
        n_res       = r_res;
        if (res_ready) begin
            n_res_valid = r_req_valid;
        end
        if (adv) begin
            n_res = dec_res;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_req_valid <= n_req_valid;
            r_res_valid <= n_res_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.operand_type  = r_res.operand_type;
    assign o_res.base_register = r_res.base_register;
    assign o_res.value         = r_res.value;
    assign o_res.index_is_word = r_res.index_is_word;
    assign o_res.scale         = r_res.scale;
    assign o_res.flags         = r_res.flags;
    assign o_res.base_disp     = r_res.base_disp;
    assign o_res.outer_disp    = r_res.outer_disp;
    assign o_res.words_used    = r_res.words_used;

endmodule

`default_nettype wire

FILE: sv/m68ea_index.sv
// m68ea_index: decodes the brief or full index extension word and its displacements
// depends on m68ea_pkg
`timescale 1ns / 1ps
`default_nettype none

module m68ea_index
    import m68ea_pkg::*;
(
    input  t_words   i_words,
    output t_idx_res o_idx
);

    logic [15:0] xw;
    logic [2:0]  sel;
    logic [2:0]  pos;
    logic [2:0]  pos_nx;
    logic        ind;

    assign xw     = i_words[0];
    assign sel    = xw[2:0];
    assign pos_nx = 3'(pos + 3'd1);

    always_comb begin
        o_idx               = '0;
        o_idx.index_reg     = xw[15:12];
        o_idx.index_is_word = ~xw[11];
        o_idx.scale         = 4'b0001 << xw[10:9];
        o_idx.words_used    = 3'd1;
        pos                 = 3'd1;
        ind                 = 1'b0;
        if (!xw[8]) begin
            // brief format: 8-bit displacement, always pre-indexed
            o_idx.base_disp       = sext8(xw[7:0]);
            o_idx.flags[FLAG_PRE] = 1'b1;
        end else begin
            o_idx.flags[FLAG_BSUP] = xw[7];
            // base displacement follows the index word
            unique case (xw[5:4])
                DSZ_WORD: begin
                    o_idx.flags[FLAG_WDISP] = 1'b1;
                    o_idx.base_disp         = sext16(i_words[1]);
                    pos                     = 3'd2;
                end
                DSZ_LONG: begin
                    o_idx.flags[FLAG_LDISP] = 1'b1;
                    o_idx.base_disp         = {i_words[1], i_words[2]};
                    pos                     = 3'd3;
                end
                default: begin
                    pos = 3'd1;
                end
            endcase
            // indirection and index position; reserved codes add nothing
            if (!xw[6]) begin
                if (sel == 3'd0) begin
                    o_idx.flags[FLAG_PRE] = 1'b1;
                end else if (sel != 3'd4) begin
                    ind = 1'b1;
                    if (sel[2]) begin
                        o_idx.flags[FLAG_POST] = 1'b1;
                    end else begin
                        o_idx.flags[FLAG_PRE] = 1'b1;
                    end
                end
            end else if (sel != 3'd0 && !sel[2]) begin
                ind = 1'b1;
            end
            o_idx.flags[FLAG_IND] = ind;
            o_idx.words_used      = pos;
            // outer displacement
            if (ind && sel[1:0] == DSZ_WORD) begin
                o_idx.flags[FLAG_WDISP2] = 1'b1;
                o_idx.outer_disp         = sext16(i_words[pos]);
                o_idx.words_used         = pos_nx;
            end else if (ind && sel[1:0] == DSZ_LONG) begin
                o_idx.flags[FLAG_LDISP2] = 1'b1;
                o_idx.outer_disp         = {i_words[pos], i_words[pos_nx]};
                o_idx.words_used         = 3'(pos + 3'd2);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/m68ea_decode.sv
// m68ea_decode: mode and register field decode of one effective address
// depends on m68ea_pkg and m68ea_index
`timescale 1ns / 1ps
`default_nettype none

module m68ea_decode
    import m68ea_pkg::*;
(
    input  t_ea_req i_req,
    output t_ea_res o_res
);

    t_idx_res    idx;
    logic [31:0] w0_sext;
    logic [31:0] w01_long;
    logic [3:0]  areg;

    m68ea_index u_index (
        .i_words (i_req.words),
        .o_idx   (idx)
    );

    assign w0_sext  = sext16(i_req.words[0]);
    assign w01_long = {i_req.words[0], i_req.words[1]};
    assign areg     = {1'b1, i_req.reg_req};

    always_comb begin
        o_res       = '0;
        o_res.scale = 4'd1;
        unique case (i_req.mode)
            MODE_DREG: begin
                o_res.operand_type = KIND_REG;
                o_res.value        = {29'd0, i_req.reg_req};
            end
            MODE_AREG: begin
                o_res.operand_type = KIND_REG;
                o_res.value        = {28'd0, areg};
            end
            MODE_DEFER: begin
                o_res.operand_type = KIND_DEFER;
                o_res.value        = {28'd0, areg};
            end
            MODE_POSTINC: begin
                o_res.operand_type = KIND_POSTINC;
                o_res.value        = {28'd0, areg};
            end
            MODE_PREDEC: begin
                o_res.operand_type = KIND_PREDEC;
                o_res.value        = {28'd0, areg};
            end
            MODE_DISPL: begin
                o_res.operand_type  = KIND_DISPL;
                o_res.base_register = areg;
                o_res.value         = w0_sext;
                o_res.words_used    = 3'd1;
            end
            MODE_INDEX: begin
                o_res.operand_type  = KIND_INDEX;
                o_res.base_register = areg;
                o_res.value         = {28'd0, idx.index_reg};
                o_res.index_is_word = idx.index_is_word;
                o_res.scale         = idx.scale;
                o_res.flags         = idx.flags;
                o_res.base_disp     = idx.base_disp;
                o_res.outer_disp    = idx.outer_disp;
                o_res.words_used    = idx.words_used;
            end
            default: begin
                unique case (i_req.reg_req)
                    EXT_ABS_W: begin
                        o_res.operand_type = KIND_ABS_W;
                        o_res.value        = w0_sext;
                        o_res.words_used   = 3'd1;
                    end
                    EXT_ABS_L: begin
                        o_res.operand_type = KIND_ABS_L;
                        o_res.value        = w01_long;
                        o_res.words_used   = 3'd2;
                    end
                    EXT_PC_DISPL: begin
                        o_res.operand_type = KIND_PC_DISPL;
                        o_res.value        = i_req.ext_addr + w0_sext;
                        o_res.words_used   = 3'd1;
                    end
                    EXT_PC_INDEX: begin
                        o_res.operand_type  = KIND_PC_INDEX;
                        o_res.value         = {28'd0, idx.index_reg};
                        o_res.index_is_word = idx.index_is_word;
                        o_res.scale         = idx.scale;
                        o_res.flags         = idx.flags;
                        o_res.base_disp     = idx.base_disp;
                        o_res.outer_disp    = idx.outer_disp;
                        o_res.words_used    = idx.words_used;
                    end
                    EXT_IMM: begin
                        o_res.operand_type = KIND_IMM;
                        if (i_req.size == SIZE_LONG) begin
                            o_res.value      = w01_long;
                            o_res.words_used = 3'd2;
                        end else if (i_req.size == SIZE_BYTE) begin
                            o_res.value      = w0_sext & IMM_BYTE_MASK;
                            o_res.words_used = 3'd1;
                        end else begin
                            o_res.value      = w0_sext;
                            o_res.words_used = 3'd1;
                        end
                    end
                    default: begin
                        o_res.operand_type = KIND_INVALID;
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire
